[src/tlpt_pkg.sv]
package tlpt_pkg;

    localparam int DIR_INDEX_BITS   = 10;
    localparam int TABLE_INDEX_BITS = 10;
    localparam int ENTRY_BITS       = DIR_INDEX_BITS + TABLE_INDEX_BITS;
    localparam int DIR_SLOTS        = 1 << DIR_INDEX_BITS;
    localparam int ENTRY_COUNT      = 1 << ENTRY_BITS;
    localparam int PAGE_SHIFT       = 12;
    localparam int WORD_BITS        = 32;

    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    localparam logic [1:0] REQ_MAP    = 2'd0;
    localparam logic [1:0] REQ_UNMAP  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        OP_MAP,
        OP_UNMAP,
        OP_LOOKUP,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        ST_DIR_EMPTY   = 2'd0,
        ST_MAPPED      = 2'd1,
        ST_ENTRY_EMPTY = 2'd2,
        ST_DONE        = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_DECIDE,
        BS_WALK,
        BS_REPLY
    } t_bstate;

    typedef struct packed {
        t_op                   op;
        logic [ENTRY_BITS-1:0] page;
        logic [WORD_BITS-1:0]  entry;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

[src/two_level_page_table_engine.sv]
// Channel   Handshake             Payload
// request   push / full           i_req_type, i_virtual_address, i_physical_address,
//                                 i_entry_flags
// result    empty / pop           o_status, o_frame_address
//
// In the back end a lookup, unmap, or map to a present directory slot does a memory
// read, then decides and writes. A map to an absent slot adds a walk of all
// 2**TABLE_INDEX_BITS entries (1024) over the entry memory port and a reply state.
// After reset the directory bits are swept to zero, one slot a cycle; full stays
// high during the sweep. A two-beat queue parts front and back, and the result
// register lets the next request start while a result waits to be popped.
module two_level_page_table_engine
    import tlpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           i_req_type,
    input  logic [WORD_BITS-1:0] i_virtual_address,
    input  logic [WORD_BITS-1:0] i_physical_address,
    input  logic [11:0]          i_entry_flags,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           o_status,
    output logic [WORD_BITS-1:0] o_frame_address
);

    t_cmd       front_cmd;
    t_cmd       head_cmd;
    logic       fifo_push;
    logic       fifo_full;
    logic       head_valid;
    logic       head_pop;
    t_back_stat back_stat;

    tlpt_front u_front (
        .i_push             (push),
        .i_req_type         (i_req_type),
        .i_virtual_address  (i_virtual_address),
        .i_physical_address (i_physical_address),
        .i_entry_flags      (i_entry_flags),
        .i_fifo_full        (fifo_full),
        .i_back_stat        (back_stat),
        .o_full             (full),
        .o_fifo_push        (fifo_push),
        .o_cmd              (front_cmd)
    );

    tlpt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (front_cmd),
        .i_pop   (head_pop),
        .o_valid (head_valid),
        .o_data  (head_cmd),
        .o_full  (fifo_full)
    );

    tlpt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (head_valid),
        .i_cmd           (head_cmd),
        .o_cmd_pop       (head_pop),
        .o_stat          (back_stat),
        .empty           (empty),
        .pop             (pop),
        .o_status        (o_status),
        .o_frame_address (o_frame_address)
    );

endmodule

[src/tlpt_fifo.sv]
module tlpt_fifo
    import tlpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data,
    output logic o_full
);

    t_cmd                     r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wptr;
    logic [FIFO_PTR_BITS-1:0] r_rptr;
    logic [FIFO_PTR_BITS:0]   r_count;
    logic                     do_push;
    logic                     do_pop;

    assign o_full  = (r_count == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/tlpt_front.sv]
module tlpt_front
    import tlpt_pkg::*;
(
    input  logic                 i_push,
    input  logic [1:0]           i_req_type,
    input  logic [WORD_BITS-1:0] i_virtual_address,
    input  logic [WORD_BITS-1:0] i_physical_address,
    input  logic [11:0]          i_entry_flags,
    input  logic                 i_fifo_full,
    input  t_back_stat           i_back_stat,
    output logic                 o_full,
    output logic                 o_fifo_push,
    output t_cmd                 o_cmd
);

    // hold off new beats while the directory sweep after reset runs
    assign o_full      = i_fifo_full || i_back_stat.clearing;
    assign o_fifo_push = i_push && !o_full;

    always_comb begin
        o_cmd.page  = i_virtual_address[PAGE_SHIFT +: ENTRY_BITS];
        o_cmd.entry = '0;
        case (i_req_type)
            REQ_MAP: begin
                o_cmd.op    = OP_MAP;
                o_cmd.entry = {i_physical_address[WORD_BITS-1:PAGE_SHIFT], i_entry_flags};
            end
            REQ_UNMAP: begin
                o_cmd.op = OP_UNMAP;
            end
            REQ_LOOKUP: begin
                o_cmd.op = OP_LOOKUP;
            end
            default: begin
                o_cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

[src/tlpt_back.sv]
module tlpt_back
    import tlpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_pop,
    output t_back_stat           o_stat,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           o_status,
    output logic [WORD_BITS-1:0] o_frame_address
);

    logic r_dir_mem [DIR_SLOTS];
    logic r_dir_rd;
    logic [WORD_BITS-1:0] r_ent_mem [ENTRY_COUNT];
    logic [WORD_BITS-1:0] r_ent_rd;

    t_bstate r_state, n_state;
    t_cmd    r_cmd;
    logic [DIR_INDEX_BITS-1:0]   r_clr_cnt, n_clr_cnt;
    logic [TABLE_INDEX_BITS-1:0] r_walk_cnt, n_walk_cnt;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [WORD_BITS-1:0] r_out_frame;

    logic                      out_free;
    logic                      rd_en;
    logic                      dir_we;
    logic [DIR_INDEX_BITS-1:0] dir_waddr;
    logic                      dir_wdata;
    logic                      ent_we;
    logic [ENTRY_BITS-1:0]     ent_waddr;
    logic [WORD_BITS-1:0]      ent_wdata;
    logic                      res_load;
    t_status                   res_status;
    logic [WORD_BITS-1:0]      res_frame;
    logic [DIR_INDEX_BITS-1:0] cmd_slot;
    logic [DIR_INDEX_BITS-1:0] head_slot;

    assign cmd_slot  = r_cmd.page[ENTRY_BITS-1 -: DIR_INDEX_BITS];
    assign head_slot = i_cmd.page[ENTRY_BITS-1 -: DIR_INDEX_BITS];
    assign out_free  = !r_out_valid || pop;

    assign o_stat.clearing = (r_state == BS_CLEAR);

    assign empty           = !r_out_valid;
    assign o_status        = r_out_status;
    assign o_frame_address = r_out_frame;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_CLEAR: begin
                if (&r_clr_cnt) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = BS_DECIDE;
                end
            end
            BS_DECIDE: begin
                if (r_cmd.op == OP_MAP && !r_dir_rd) begin
                    n_state = BS_WALK;
                end else if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
            BS_WALK: begin
                if (&r_walk_cnt) begin
                    n_state = BS_REPLY;
                end
            end
            BS_REPLY: begin
                if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd_pop  = 1'b0;
        rd_en      = 1'b0;
        dir_we     = 1'b0;
        dir_waddr  = cmd_slot;
        dir_wdata  = 1'b1;
        ent_we     = 1'b0;
        ent_waddr  = r_cmd.page;
        ent_wdata  = r_cmd.entry;
        res_load   = 1'b0;
        res_status = ST_DONE;
        res_frame  = '0;
        n_clr_cnt  = r_clr_cnt;
        n_walk_cnt = r_walk_cnt;
        case (r_state)
            BS_CLEAR: begin
                dir_we    = 1'b1;
                dir_waddr = r_clr_cnt;
                dir_wdata = 1'b0;
                n_clr_cnt = r_clr_cnt + 1'b1;
            end
            BS_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                rd_en     = i_cmd_valid;
            end
            BS_DECIDE: begin
                n_walk_cnt = '0;
                if (r_cmd.op == OP_MAP && !r_dir_rd) begin
                    // new table: mark present, then walk it
                    dir_we = 1'b1;
                end else if (out_free) begin
                    res_load = 1'b1;
                    case (r_cmd.op)
                        OP_MAP, OP_UNMAP: begin
                            ent_we = 1'b1;
                        end
                        OP_LOOKUP: begin
                            if (!r_dir_rd) begin
                                res_status = ST_DIR_EMPTY;
                            end else if (r_ent_rd != '0) begin
                                res_status = ST_MAPPED;
                                res_frame  = {r_ent_rd[WORD_BITS-1:PAGE_SHIFT],
                                              PAGE_SHIFT'(0)};
                            end else begin
                                res_status = ST_ENTRY_EMPTY;
                            end
                        end
                        default: res_status = ST_DONE;
                    endcase
                end
            end
            BS_WALK: begin
                // zero the table, dropping the new entry in at its own slot
                ent_we     = 1'b1;
                ent_waddr  = {cmd_slot, r_walk_cnt};
                ent_wdata  = (r_walk_cnt == r_cmd.page[TABLE_INDEX_BITS-1:0]) ?
                             r_cmd.entry : '0;
                n_walk_cnt = r_walk_cnt + 1'b1;
            end
            BS_REPLY: begin
                res_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            r_dir_mem[dir_waddr] <= dir_wdata;
        end
        if (rd_en) begin
            r_dir_rd <= r_dir_mem[head_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[ent_waddr] <= ent_wdata;
        end
        if (rd_en) begin
            r_ent_rd <= r_ent_mem[i_cmd.page];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (res_load) begin
            r_out_status <= res_status;
            r_out_frame  <= res_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_clr_cnt   <= '0;
            r_walk_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_cnt  <= n_clr_cnt;
            r_walk_cnt <= n_walk_cnt;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[bench/tb.sv]
module tb;
    import tlpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam int         RANDOM_ITEMS   = 1900;
    localparam int         WATCHDOG_LIMIT = 10000;

    typedef struct {
        t_status              status;
        logic [WORD_BITS-1:0] frame;
    } t_reply;

    class page_table_tracker;
        bit                        dir_present [DIR_SLOTS];
        logic [WORD_BITS-1:0]      entry_store [bit [ENTRY_BITS-1:0]];
        t_reply                    due_replies [$];
        int                        mismatches;
        int                        replies_seen;
        int                        tables_built;
        int                        requests_by_kind [4];

        task report_mismatch(string what);
            mismatches++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        // Advance the table state by one request and queue the reply it causes.
        function void accept_request(logic [1:0] kind, logic [WORD_BITS-1:0] va,
                                     logic [WORD_BITS-1:0] pa, logic [11:0] flags);
            bit [ENTRY_BITS-1:0]       page;
            bit [DIR_INDEX_BITS-1:0]   slot;
            bit [TABLE_INDEX_BITS-1:0] idx;
            t_reply                    reply;
            page = va[PAGE_SHIFT +: ENTRY_BITS];
            slot = page[ENTRY_BITS-1 -: DIR_INDEX_BITS];
            reply.status = ST_DONE;
            reply.frame = '0;
            requests_by_kind[kind]++;
            case (kind)
                REQ_MAP: begin
                    if (!dir_present[slot]) begin
                        dir_present[slot] = 1'b1;
                        tables_built++;
                        for (int i = 0; i < (1 << TABLE_INDEX_BITS); i++) begin
                            idx = i[TABLE_INDEX_BITS-1:0];
                            entry_store[{slot, idx}] = '0;
                        end
                    end
                    entry_store[page] = {pa[WORD_BITS-1:PAGE_SHIFT], flags};
                end
                REQ_UNMAP: begin
                    entry_store[page] = '0;
                end
                REQ_LOOKUP: begin
                    if (!dir_present[slot]) begin
                        reply.status = ST_DIR_EMPTY;
                    end else if (entry_store[page] != '0) begin
                        reply.status = ST_MAPPED;
                        reply.frame = {entry_store[page][WORD_BITS-1:PAGE_SHIFT],
                                       {PAGE_SHIFT{1'b0}}};
                    end else begin
                        reply.status = ST_ENTRY_EMPTY;
                    end
                end
                default: ;
            endcase
            due_replies.push_back(reply);
        endfunction

        task check_reply(t_status status, logic [WORD_BITS-1:0] frame);
            t_reply want;
            replies_seen++;
            if (due_replies.size() == 0) begin
                report_mismatch($sformatf("reply %0d with nothing pending", replies_seen));
            end else begin
                want = due_replies.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                              replies_seen, status, want.status));
                if (frame !== want.frame)
                    report_mismatch($sformatf("reply %0d frame %h, want %h",
                                              replies_seen, frame, want.frame));
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [1:0]           i_req_type;
    logic [WORD_BITS-1:0] i_virtual_address;
    logic [WORD_BITS-1:0] i_physical_address;
    logic [11:0]          i_entry_flags;
    logic                 empty;
    logic                 pop;
    logic [1:0]           o_status;
    logic [WORD_BITS-1:0] o_frame_address;

    page_table_tracker    tracker;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   idle_cycles;
    bit [DIR_INDEX_BITS-1:0]   hot_slots [6];
    bit [TABLE_INDEX_BITS-1:0] hot_tables [32];

    two_level_page_table_engine i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_req_type         (i_req_type),
        .i_virtual_address  (i_virtual_address),
        .i_physical_address (i_physical_address),
        .i_entry_flags      (i_entry_flags),
        .empty              (empty),
        .pop                (pop),
        .o_status           (o_status),
        .o_frame_address    (o_frame_address)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            tracker.check_reply(t_status'(o_status), o_frame_address);
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_request(input logic [1:0] kind, input logic [WORD_BITS-1:0] va,
                                input logic [WORD_BITS-1:0] pa, input logic [11:0] flags);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push               <= 1'b1;
        i_req_type         <= kind;
        i_virtual_address  <= va;
        i_physical_address <= pa;
        i_entry_flags      <= flags;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        tracker.accept_request(kind, va, pa, flags);
        @(negedge i_clk);
    endtask

    // Mostly a few hot tables so maps and lookups meet; now and then anywhere.
    function automatic logic [WORD_BITS-1:0] pick_address();
        if ($urandom_range(99) < 2)
            return $urandom();
        return {hot_slots[$urandom_range(5)], hot_tables[$urandom_range(31)],
                12'($urandom())};
    endfunction

    initial begin
        int                   roll;
        logic [1:0]           kind;
        logic [WORD_BITS-1:0] pa;
        logic [11:0]          flags;

        tracker = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_req_type = REQ_LOOKUP;
        i_virtual_address = '0;
        i_physical_address = '0;
        i_entry_flags = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_cycles = 0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty directory, table creation, zero and flag-only entries.
        send_request(REQ_LOOKUP, 32'h0000_0000, '0, '0);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0);
        send_request(REQ_UNMAP,  32'h0040_0000, '0, '0);
        send_request(REQ_LOOKUP, 32'h0040_0000, '0, '0);
        send_request(REQ_MAP,    32'h0040_0000, 32'hFFFF_FFFF, 12'hFFF);
        send_request(REQ_LOOKUP, 32'h0040_0FFF, '0, '0);
        send_request(REQ_LOOKUP, 32'h0040_1000, '0, '0);
        send_request(REQ_MAP,    32'hFFFF_FFFF, '0, '0);
        send_request(REQ_LOOKUP, 32'hFFFF_F000, '0, '0);
        send_request(REQ_MAP,    32'hFFFF_F000, 32'h0000_0FFF, 12'hABC);
        send_request(REQ_LOOKUP, 32'hFFFF_F123, '0, '0);
        send_request(REQ_UNMAP,  32'h0040_0FFF, '0, '0);
        send_request(REQ_LOOKUP, 32'h0040_0000, '0, '0);
        send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0);
        send_request(REQ_MAP,    32'h0000_0000, 32'h1234_5678, 12'h5A5);
        send_request(REQ_LOOKUP, 32'h0000_0000, '0, '0);
        send_request(REQ_MAP,    32'h0000_0000, 32'hEDCB_A987, 12'h000);
        send_request(REQ_LOOKUP, 32'h0000_0ABC, '0, '0);
        send_request(REQ_LOOKUP, 32'h0000_1000, '0, '0);
        send_request(REQ_UNMAP,  32'hFFFF_FFFF, '0, '0);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0);

        foreach (hot_slots[i]) hot_slots[i] = DIR_INDEX_BITS'($urandom());
        foreach (hot_tables[i]) hot_tables[i] = TABLE_INDEX_BITS'($urandom());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / 120) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            roll = $urandom_range(99);
            if (roll < 35)      kind = REQ_MAP;
            else if (roll < 50) kind = REQ_UNMAP;
            else if (roll < 95) kind = REQ_LOOKUP;
            else                kind = REQ_UNUSED;
            pa = $urandom();
            if ($urandom_range(99) < 5) pa = pa & 32'h0000_0FFF;
            flags = 12'($urandom_range(4095));
            if ($urandom_range(99) < 10) flags = '0;
            send_request(kind, pick_address(), pa, flags);
        end

        push <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (tracker.due_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d map, %0d unmap, %0d lookup, %0d unused requests",
                 tracker.requests_by_kind[REQ_MAP], tracker.requests_by_kind[REQ_UNMAP],
                 tracker.requests_by_kind[REQ_LOOKUP], tracker.requests_by_kind[REQ_UNUSED]);
        $display("%0d replies checked, %0d tables built, %0d mismatches",
                 tracker.replies_seen, tracker.tables_built, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.due_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
src/tlpt_pkg.sv
src/tlpt_fifo.sv
src/tlpt_front.sv
src/tlpt_back.sv
src/two_level_page_table_engine.sv
bench/tb.sv
